FILE: hw/rtl/svd_pkg.sv
// Shared types and constants for the semantic vector distance block.
`default_nettype none
package svd_pkg;
  localparam int MaxLen = 1024;
  localparam int CntW = 11;
  localparam int QDepth = 2;

  // Totals of one finished vector pair, handed from the front to the back.
  typedef struct packed {
    logic [34:0]        abs_sum;
    logic signed [58:0] dot_sum;
    logic [57:0]        norm_a;
    logic [57:0]        norm_b;
    logic [CntW-1:0]    unequal;
    logic [CntW-1:0]    pairs;
    logic               over;
  } svd_acc_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQRT, S_COS, S_MEAN, S_OUT
  } svd_state_t;

  localparam logic [0:0] ModeMean = 1'b0;
  localparam logic [0:0] ModeCos = 1'b1;
  localparam logic [0:0] RegDistanceMode = 1'b0;
endpackage
`default_nettype wire

FILE: hw/rtl/semantic_vector_distance.sv
// Top level of the semantic vector distance block with its register port.
// One element pair is taken per cycle while the front is not stalled; pairs flow through
// a product register into the accumulators. On the pair marked last the totals move
// into a two-entry queue and the back end works on them alone: the mean mode runs a
// bit-serial division, the cosine mode a shift-add product of the norms, a square root
// and a ratio division, after a state that loads the totals and before a state that
// presents the result. A zero norm in cosine mode goes straight to the result.
// The front keeps accepting pairs while the back end is busy; it stalls only when the
// queue holds two finished vectors and the last pair of a third is waiting.
`default_nettype none
module semantic_vector_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // elem_a [23:0], elem_b [47:24]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // distance [23:0], mismatch_count [34:24], zero_magnitude [35],
  // length_overflow [36], zero fill [39:37]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic              distance_mode;
  logic              push;
  svd_pkg::svd_acc_t push_data;
  logic              q_ready;
  logic              q_valid;
  logic              pop;
  svd_pkg::svd_acc_t pop_data;
  logic [23:0]       distance;
  logic [10:0]       mismatch_count;
  logic              zero_magnitude;
  logic              length_overflow;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == svd_pkg::RegDistanceMode) ? {31'd0, distance_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == svd_pkg::RegDistanceMode) begin
      distance_mode <= pwdata[0];
    end
  end

  svd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .elem_a    (s_axis_tdata[23:0]),
    .elem_b    (s_axis_tdata[47:24]),
    .last      (s_axis_tlast),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready)
  );

  svd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  svd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .mode            (distance_mode),
    .q_valid         (q_valid),
    .q_data          (pop_data),
    .pop             (pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .distance        (distance),
    .mismatch_count  (mismatch_count),
    .zero_magnitude  (zero_magnitude),
    .length_overflow (length_overflow)
  );

  assign m_axis_tdata = {3'b000, length_overflow, zero_magnitude, mismatch_count, distance};
endmodule
`default_nettype wire

FILE: hw/rtl/svd_front.sv
// Front end: registers per-pair products and accumulates them into vector totals.
`default_nettype none
module svd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] elem_a,
  input  wire logic signed [23:0] elem_b,
  input  wire logic               last,
  output logic                    push,
  output svd_pkg::svd_acc_t       push_data,
  input  wire logic               q_ready
);
  logic               p_valid;
  logic               p_last;
  logic [23:0]        p_abs;
  logic signed [47:0] p_dot;
  logic [46:0]        p_na;
  logic [46:0]        p_nb;
  logic               p_neq;

  logic [34:0]        abs_sum, abs_sum_next;
  logic signed [58:0] dot_sum, dot_sum_next;
  logic [57:0]        norm_a, norm_a_next;
  logic [57:0]        norm_b, norm_b_next;
  logic [svd_pkg::CntW-1:0] unequal, unequal_next;
  logic [svd_pkg::CntW-1:0] pairs, pairs_next;
  logic               over, over_next;

  logic signed [24:0] diff;
  logic signed [47:0] sq_a;
  logic signed [47:0] sq_b;
  logic               room;

  assign in_ready = !(p_valid && p_last && !q_ready);
  assign push = p_valid && p_last && in_ready;

  assign diff = {elem_a[23], elem_a} - {elem_b[23], elem_b};
  assign sq_a = elem_a * elem_a;
  assign sq_b = elem_b * elem_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
    if (in_ready) begin
      p_last <= last;
      p_abs <= diff[24] ? 24'(-diff) : diff[23:0];
      p_dot <= elem_a * elem_b;
      p_na <= sq_a[46:0];
      p_nb <= sq_b[46:0];
      p_neq <= (diff != '0);
    end
  end

  assign room = (pairs < svd_pkg::CntW'(svd_pkg::MaxLen));

  always_comb begin
    abs_sum_next = abs_sum;
    dot_sum_next = dot_sum;
    norm_a_next = norm_a;
    norm_b_next = norm_b;
    unequal_next = unequal;
    pairs_next = pairs;
    over_next = over;
    if (p_valid) begin
      if (room) begin
        abs_sum_next = abs_sum + 35'(p_abs);
        dot_sum_next = dot_sum + 59'(p_dot);
        norm_a_next = norm_a + 58'(p_na);
        norm_b_next = norm_b + 58'(p_nb);
        unequal_next = unequal + svd_pkg::CntW'(p_neq);
        pairs_next = pairs + svd_pkg::CntW'(1);
      end else begin
        over_next = 1'b1;
      end
    end
  end

  always_comb begin
    push_data.abs_sum = abs_sum_next;
    push_data.dot_sum = dot_sum_next;
    push_data.norm_a = norm_a_next;
    push_data.norm_b = norm_b_next;
    push_data.unequal = unequal_next;
    push_data.pairs = pairs_next;
    push_data.over = over_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      abs_sum <= '0;
      dot_sum <= '0;
      norm_a <= '0;
      norm_b <= '0;
      unequal <= '0;
      pairs <= '0;
      over <= 1'b0;
    end else if (in_ready) begin
      abs_sum <= abs_sum_next;
      dot_sum <= dot_sum_next;
      norm_a <= norm_a_next;
      norm_b <= norm_b_next;
      unequal <= unequal_next;
      pairs <= pairs_next;
      over <= over_next;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/svd_queue.sv
// Two-entry queue of vector totals between the front and back ends.
`default_nettype none
module svd_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  svd_pkg::svd_acc_t push_data,
  output logic              q_ready,
  output logic              q_valid,
  input  wire logic         pop,
  output svd_pkg::svd_acc_t pop_data
);
  svd_pkg::svd_acc_t slots [svd_pkg::QDepth];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign q_ready = (fill != 2'(svd_pkg::QDepth));
  assign q_valid = (fill != 2'd0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/svd_back.sv
// Back end: mean division or product, square root and cosine division per vector pair.
`default_nettype none
module svd_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         mode,
  input  wire logic         q_valid,
  input  svd_pkg::svd_acc_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [23:0]       distance,
  output logic [10:0]       mismatch_count,
  output logic              zero_magnitude,
  output logic              length_overflow
);
  svd_pkg::svd_state_t state, state_next;
  logic [6:0]   cnt;
  logic [115:0] mcand;
  logic [57:0]  mplier;
  logic [115:0] prod;
  logic [60:0]  srem;
  logic [57:0]  root;
  logic [59:0]  crem;
  logic [13:0]  quo;
  logic         dneg;
  logic [34:0]  dvd;
  logic [10:0]  mrem;
  logic [10:0]  den;

  logic [60:0]  s_sh;
  logic [60:0]  s_trial;
  logic [59:0]  c_m;
  logic [59:0]  c_sh;
  logic [59:0]  c_sub;
  logic [11:0]  m_sh;
  logic         nz;
  logic [13:0]  q_clamp;

  assign nz = (q_data.norm_a != '0) && (q_data.norm_b != '0);
  assign s_sh = {srem[58:0], prod[115:114]};
  assign s_trial = {1'b0, root, 2'b01};
  assign c_m = {2'b00, root};
  assign c_sh = {crem[58:0], 1'b0};
  assign c_sub = crem - c_m;
  assign m_sh = {mrem, dvd[34]};
  assign q_clamp = (quo > 14'd4096) ? 14'd4096 : quo;

  always_comb begin
    state_next = state;
    unique case (state)
      svd_pkg::S_IDLE: begin
        if (q_valid) begin
          if (mode == svd_pkg::ModeMean) begin
            state_next = svd_pkg::S_MEAN;
          end else if (nz) begin
            state_next = svd_pkg::S_MUL;
          end else begin
            state_next = svd_pkg::S_OUT;
          end
        end
      end
      svd_pkg::S_MUL:  if (cnt == 7'd1) state_next = svd_pkg::S_SQRT;
      svd_pkg::S_SQRT: if (cnt == 7'd1) state_next = svd_pkg::S_COS;
      svd_pkg::S_COS:  if (cnt == 7'd0) state_next = svd_pkg::S_OUT;
      svd_pkg::S_MEAN: if (cnt == 7'd1) state_next = svd_pkg::S_OUT;
      svd_pkg::S_OUT:  if (out_ready) state_next = svd_pkg::S_IDLE;
      default:         state_next = svd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == svd_pkg::S_IDLE) && q_valid;
    out_valid = (state == svd_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      svd_pkg::S_IDLE: begin
        mismatch_count <= q_data.unequal;
        length_overflow <= q_data.over;
        zero_magnitude <= (mode == svd_pkg::ModeCos) && !nz;
        distance <= 24'd4096;
        dvd <= q_data.abs_sum;
        den <= q_data.pairs;
        mrem <= '0;
        mcand <= {58'd0, q_data.norm_a};
        mplier <= q_data.norm_b;
        prod <= '0;
        srem <= '0;
        root <= '0;
        quo <= '0;
        dneg <= q_data.dot_sum[58];
        crem <= q_data.dot_sum[58] ? 60'(-q_data.dot_sum) : 60'(q_data.dot_sum);
        cnt <= (mode == svd_pkg::ModeMean) ? 7'd35 : 7'd58;
      end
      svd_pkg::S_MUL: begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand <= {mcand[114:0], 1'b0};
        mplier <= {1'b0, mplier[57:1]};
        cnt <= (cnt == 7'd1) ? 7'd58 : cnt - 7'd1;
      end
      svd_pkg::S_SQRT: begin
        // Two radicand bits per step, restoring digit-by-digit square root.
        prod <= {prod[113:0], 2'b00};
        if (s_sh >= s_trial) begin
          srem <= s_sh - s_trial;
          root <= {root[56:0], 1'b1};
        end else begin
          srem <= s_sh;
          root <= {root[56:0], 1'b0};
        end
        cnt <= (cnt == 7'd1) ? 7'd13 : cnt - 7'd1;
      end
      svd_pkg::S_COS: begin
        if (cnt == 7'd13) begin
          // Integer part of the ratio is one at most; anything larger is dropped.
          if (crem >= c_m) begin
            quo <= 14'd1;
            crem <= (c_sub >= c_m) ? '0 : c_sub;
          end
        end else if (cnt != 7'd0) begin
          if (c_sh >= c_m) begin
            crem <= c_sh - c_m;
            quo <= {quo[12:0], 1'b1};
          end else begin
            crem <= c_sh;
            quo <= {quo[12:0], 1'b0};
          end
        end else begin
          distance <= dneg ? 24'(14'd4096 + q_clamp) : 24'(14'd4096 - q_clamp);
        end
        cnt <= cnt - 7'd1;
      end
      svd_pkg::S_MEAN: begin
        if (m_sh >= {1'b0, den}) begin
          mrem <= 11'(m_sh - {1'b0, den});
          dvd <= {dvd[33:0], 1'b1};
        end else begin
          mrem <= m_sh[10:0];
          dvd <= {dvd[33:0], 1'b0};
        end
        if (cnt == 7'd1) begin
          distance <= (den == '0) ? 24'd0 : (m_sh >= {1'b0, den}) ?
                      {dvd[22:0], 1'b1} : {dvd[22:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
      end
      svd_pkg::S_OUT: begin
        cnt <= '0;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Testbench for semantic_vector_distance: directed table and random vectors vs. a predictor.
`timescale 1ns / 100ps
module testbench;

  typedef struct {
    logic [23:0] dval;
    logic [10:0] mism;
    logic        zmag;
    logic        ovf;
  } dist_res_t;

  typedef struct {
    logic [0:0]         mode;
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic               last;
    logic               typed;
    dist_res_t          res;
  } stim_row_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tlast, m_axis_tready;
  logic [47:0] s_axis_tdata;  // elem_a [23:0], elem_b [47:24]
  logic s_axis_tready, m_axis_tvalid;
  // distance [23:0], mismatch_count [34:24], zero_magnitude [35], length_overflow [36]
  logic [39:0] m_axis_tdata;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  semantic_vector_distance dut (.*);

  // Predictor state.
  logic [0:0]  cur_mode;
  logic [63:0] sum_abs, sum_na, sum_nb;
  longint      sum_dot;
  int          n_unequal, n_pairs;
  logic        too_long;

  dist_res_t   pending_dist[$];
  int          errors = 0;
  bit          quiet = 0;
  int          sent = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void clear_sums();
    sum_abs = 0; sum_na = 0; sum_nb = 0; sum_dot = 0;
    n_unequal = 0; n_pairs = 0; too_long = 0;
  endfunction

  // Accumulates one pair; returns 1 with the vector's distance when last is set.
  function automatic bit accumulate_pair(logic signed [23:0] a, logic signed [23:0] b,
                                         logic last, output dist_res_t res);
    longint la, lb, d, ar;
    logic [127:0] prod, cand;
    logic [63:0] m, q, rem;
    la = a; lb = b;
    if (n_pairs >= svd_pkg::MaxLen) begin
      too_long = 1;
    end else begin
      d = la - lb;
      sum_abs += (d < 0) ? -d : d;
      sum_dot += la * lb;
      sum_na += la * la;
      sum_nb += lb * lb;
      if (d != 0) n_unequal++;
      n_pairs++;
    end
    if (!last) return 0;
    res.zmag = 0;
    if (cur_mode == svd_pkg::ModeMean) begin
      res.dval = 24'(sum_abs / n_pairs);
    end else if (sum_na == 0 || sum_nb == 0) begin
      res.dval = 24'd4096;
      res.zmag = 1;
    end else begin
      prod = {64'd0, sum_na} * {64'd0, sum_nb};
      m = 0;
      for (int i = 57; i >= 0; i--) begin
        cand = {64'd0, m | (64'd1 << i)};
        if (cand * cand <= prod) m = m | (64'd1 << i);
      end
      ar = (sum_dot < 0) ? -sum_dot : sum_dot;
      rem = ar;
      q = 0;
      if (rem >= m) begin
        q = 1;
        rem -= m;
        if (rem >= m) rem = 0;
      end
      for (int i = 0; i < 12; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= m) begin
          rem -= m;
          q |= 1;
        end
      end
      if (q > 4096) q = 4096;
      res.dval = (sum_dot < 0) ? 24'(4096 + q) : 24'(4096 - q);
    end
    res.mism = 11'(n_unequal);
    res.ovf = too_long;
    clear_sums();
    return 1;
  endfunction

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    // The pending transfer completes at this edge; nothing more is offered.
    @(posedge clk);
    s_axis_tvalid <= 0;
    s_axis_tlast <= 0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_mode(logic [0:0] mode);
    drain();
    reg_write({svd_pkg::RegDistanceMode, 2'b00}, {31'd0, mode});
    cur_mode = mode;
  endtask

  // Sends one pair; a typed expectation replaces the predicted one when given.
  task automatic send_pair(logic signed [23:0] a, logic signed [23:0] b, logic last,
                           bit typed = 0, dist_res_t typed_res = '{default: 0});
    dist_res_t res;
    bit ok;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(posedge clk);
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 16) - 1) @(posedge clk);
    end
    @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {b, a};
    s_axis_tlast <= last;
    do begin
      @(negedge clk);
      ok = s_axis_tready;
    end while (!ok);
    if (accumulate_pair(a, b, last, res)) begin
      if (typed) res = typed_res;
      pending_dist.insert(pending_dist.size(), res);
    end
    sent++;
  endtask

  always @(negedge clk) begin
    dist_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        e = pending_dist.pop_front();
        if (m_axis_tdata[23:0] !== e.dval) begin
          $display("%0t: distance expected %0d actual %0d", $realtime, e.dval,
                   m_axis_tdata[23:0]);
          errors++;
        end
        if (m_axis_tdata[34:24] !== e.mism) begin
          $display("%0t: mismatch_count expected %0d actual %0d", $realtime, e.mism,
                   m_axis_tdata[34:24]);
          errors++;
        end
        if (m_axis_tdata[35] !== e.zmag) begin
          $display("%0t: zero_magnitude expected %0d actual %0d", $realtime, e.zmag,
                   m_axis_tdata[35]);
          errors++;
        end
        if (m_axis_tdata[36] !== e.ovf) begin
          $display("%0t: length_overflow expected %0d actual %0d", $realtime, e.ovf,
                   m_axis_tdata[36]);
          errors++;
        end
      end
    end
  end

  // Result-side backpressure in random bursts.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk);
      end
    end
  end

  function automatic logic signed [23:0] pick_elem();
    case ($urandom_range(0, 7))
      0, 1:    return 24'($urandom);
      2, 3:    return 24'($signed($urandom_range(0, 127)) - 64);
      4:       return 24'sh7FFFFF;
      5:       return -24'sh800000;
      6:       return 24'($signed($urandom_range(0, 65535)) - 32768);
      default: return 24'd0;
    endcase
  endfunction

  task automatic send_vector(int len, bit zero_a, bit zero_b);
    logic signed [23:0] a, b;
    for (int i = 0; i < len; i++) begin
      a = zero_a ? 24'sd0 : pick_elem();
      case ($urandom_range(0, 3))
        0:       b = a;
        1:       b = a + 24'($signed($urandom_range(0, 15)) - 8);
        default: b = pick_elem();
      endcase
      if (zero_b) b = 0;
      send_pair(a, b, i == len - 1);
    end
  endtask

  stim_row_t dir_rows[] = '{
    '{svd_pkg::ModeMean, 24'sd0, 24'sd0, 1, 1, '{24'd0, 11'd0, 0, 0}},
    '{svd_pkg::ModeMean, 24'sh7FFFFF, -24'sh800000, 1, 1, '{24'd16777215, 11'd1, 0, 0}},
    '{svd_pkg::ModeMean, -24'sh800000, -24'sh800000, 1, 1, '{24'd0, 11'd0, 0, 0}},
    '{svd_pkg::ModeMean, 24'sd5, 24'sd3, 0, 0, '{default: 0}},
    '{svd_pkg::ModeMean, 24'sd1, -24'sd1, 1, 0, '{default: 0}},
    '{svd_pkg::ModeCos, 24'sd0, 24'sd7, 1, 1, '{24'd4096, 11'd1, 1, 0}},
    '{svd_pkg::ModeCos, 24'sd9, 24'sd0, 1, 1, '{24'd4096, 11'd1, 1, 0}},
    '{svd_pkg::ModeCos, -24'sh800000, -24'sh800000, 1, 1, '{24'd0, 11'd0, 0, 0}},
    '{svd_pkg::ModeCos, 24'sh7FFFFF, -24'sh800000, 1, 0, '{default: 0}},
    '{svd_pkg::ModeCos, 24'sd3, -24'sd3, 1, 1, '{24'd8192, 11'd1, 0, 0}},
    '{svd_pkg::ModeCos, 24'sd1, 24'sd0, 0, 0, '{default: 0}},
    '{svd_pkg::ModeCos, 24'sd0, 24'sd1, 1, 1, '{24'd4096, 11'd2, 0, 0}},
    '{svd_pkg::ModeCos, 24'sd100, 24'sd200, 0, 0, '{default: 0}},
    '{svd_pkg::ModeCos, 24'sd300, -24'sd50, 0, 0, '{default: 0}},
    '{svd_pkg::ModeCos, 24'sd7, 24'sd7, 1, 0, '{default: 0}},
    '{svd_pkg::ModeMean, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, '{default: 0}},
    '{svd_pkg::ModeMean, -24'sd4096, 24'sd4095, 1, 0, '{default: 0}}
  };

  initial begin
    int plen;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cur_mode = svd_pkg::ModeMean;
    clear_sums();
    repeat (12) @(posedge clk);
    rst <= 0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) set_mode(dir_rows[i].mode);
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].res);
    end

    // Random phases alternate the mode; one phase carries a vector past the length limit.
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0] ? svd_pkg::ModeCos : svd_pkg::ModeMean);
      if (ph == 5) quiet = 1;
      if (ph == 2) send_vector(1026, 0, 0);
      plen = sent + 75;
      while (sent < plen) begin
        case ($urandom_range(0, 9))
          0:       send_vector($urandom_range(1, 6), 1, 0);
          1:       send_vector($urandom_range(1, 6), 0, 1);
          default: send_vector($urandom_range(1, 16), 0, 0);
        endcase
      end
    end

    @(posedge clk);
    s_axis_tvalid <= 0;
    s_axis_tlast <= 0;
    drain();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/svd_pkg.sv
hw/rtl/svd_front.sv
hw/rtl/svd_queue.sv
hw/rtl/svd_back.sv
hw/rtl/semantic_vector_distance.sv
sim/testbench.sv
